/* hw/rtl/spm_pkg.sv */
package spm_pkg;

    // command codes carried in tuser of the input stream
    localparam logic [1:0] CMD_LOAD_FIRST  = 2'd0;
    localparam logic [1:0] CMD_LOAD_SECOND = 2'd1;
    localparam logic [1:0] CMD_MULTIPLY    = 2'd2;

    localparam int COEF_W     = 32;
    localparam int IN_EXP_W   = 16;
    localparam int OUT_EXP_W  = 17;
    localparam int STORE_CAP  = 8;
    localparam int TABLE_CAP  = STORE_CAP * STORE_CAP;
    localparam int TABLE_AW   = 6;
    localparam int PCOUNT_W   = 7;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 56;

endpackage

/* hw/rtl/sparse_polynomial_multiply_core.sv */
// sparse polynomial multiply core
// loads produce no word; a multiply command runs the term pairs through the
// product table one pair at a time: each pair is read, multiplied, scanned
// against the table entries and added in, or inserted after the entries below
// it are shifted; the result words then follow from the table. rst_n clears counts, flag
// and handshakes at once; the stores and the table need no clearing pass
module sparse_polynomial_multiply_core #(
    parameter int MAX_TERMS = 8,
    parameter int EXP_BITS  = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // input stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [spm_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // coefficient[31:0], exponent[47:32]
    input  logic [1:0]                      s_axis_tuser,  // command[1:0]
    // result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [spm_pkg::OUT_DATA_W-1:0]  m_axis_tdata,  // coefficient_out[31:0], exponent_out[48:32], zero pad
    output logic                            m_axis_tlast,  // last
    output logic [1:0]                      m_axis_tuser   // empty_res[0], overflow[1]
);

    localparam int SW = EXP_BITS + 1;                         // product exponent width
    localparam int DW = spm_pkg::COEF_W + SW;                 // table entry width
    localparam int IW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CW = $clog2(MAX_TERMS + 1);

    typedef struct packed {
        logic signed [spm_pkg::COEF_W-1:0] coef;
        logic signed [EXP_BITS-1:0]        exp;
    } term_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RD, ST_MUL, ST_SCAN, ST_CMP, ST_SHRD, ST_SHWR,
        ST_INS, ST_NEXT, ST_EMRD, ST_EMLD
    } state_t;

    state_t state_reg;

    // operand stores
    term_t first_mem  [MAX_TERMS];
    term_t second_mem [MAX_TERMS];
    term_t a_rd_reg, b_rd_reg;

    logic [CW-1:0] first_count_reg, second_count_reg;
    logic [CW-1:0] i_reg, j_reg;
    logic          dropped_reg;
    logic          ovf_reg;

    // current product term
    logic [spm_pkg::COEF_W-1:0] prod_coef_reg;
    logic signed [SW-1:0]       prod_exp_reg;

    // table walk
    logic [spm_pkg::PCOUNT_W-1:0] pcount_reg, k_reg, pos_reg, m_reg;

    // table port
    logic                          tab_we;
    logic [spm_pkg::TABLE_AW-1:0]  tab_waddr, tab_raddr;
    logic [DW-1:0]                 tab_wdata, tab_rdata;
    logic signed [SW-1:0]          tab_exp;
    logic [spm_pkg::COEF_W-1:0]    tab_coef;

    // output register
    logic                          out_valid_reg;
    logic [spm_pkg::COEF_W-1:0]    out_coef_reg;
    logic [spm_pkg::OUT_EXP_W-1:0] out_exp_reg, out_exp_cvt;
    logic                          out_last_reg, out_empty_reg, out_ovf_reg;

    term_t         ld_term;
    logic          in_acc;
    logic          first_full, second_full;

    assign tab_exp  = tab_rdata[SW-1:0];
    assign tab_coef = tab_rdata[DW-1:SW];

    // loaded exponent: sign-extend from 16 bits, wrap to EXP_BITS
    // table exponent to the 17-bit output field
    generate
        if (EXP_BITS <= spm_pkg::IN_EXP_W)
        begin : g_ld_narrow
            assign ld_term.exp = s_axis_tdata[spm_pkg::COEF_W +: EXP_BITS];
        end
        else
        begin : g_ld_wide
            assign ld_term.exp = {{(EXP_BITS - spm_pkg::IN_EXP_W){s_axis_tdata[47]}},
                                  s_axis_tdata[47:32]};
        end
        if (SW >= spm_pkg::OUT_EXP_W)
        begin : g_out_trunc
            assign out_exp_cvt = tab_exp[spm_pkg::OUT_EXP_W-1:0];
        end
        else
        begin : g_out_ext
            assign out_exp_cvt = {{(spm_pkg::OUT_EXP_W - SW){tab_exp[SW-1]}}, tab_exp};
        end
    endgenerate
    assign ld_term.coef = s_axis_tdata[spm_pkg::COEF_W-1:0];

    assign s_axis_tready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign first_full    = (first_count_reg == CW'(MAX_TERMS));
    assign second_full   = (second_count_reg == CW'(MAX_TERMS));

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_exp_reg, out_coef_reg};
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = {out_ovf_reg, out_empty_reg};

    // store writes and registered reads
    always_ff @(posedge clk)
    begin
        if (in_acc && s_axis_tuser == spm_pkg::CMD_LOAD_FIRST && !first_full)
        begin
            first_mem[first_count_reg[IW-1:0]] <= ld_term;
        end
        if (in_acc && s_axis_tuser == spm_pkg::CMD_LOAD_SECOND && !second_full)
        begin
            second_mem[second_count_reg[IW-1:0]] <= ld_term;
        end
        a_rd_reg <= first_mem[i_reg[IW-1:0]];
        b_rd_reg <= second_mem[j_reg[IW-1:0]];
    end

    // table port control
    always_comb
    begin
        tab_we    = 1'b0;
        tab_waddr = k_reg[spm_pkg::TABLE_AW-1:0];
        tab_wdata = {tab_coef + prod_coef_reg, tab_exp};
        tab_raddr = k_reg[spm_pkg::TABLE_AW-1:0];
        unique case (state_reg)
            ST_CMP:
            begin
                tab_we = (tab_exp == prod_exp_reg);
            end
            ST_SHRD:
            begin
                tab_raddr = spm_pkg::TABLE_AW'(m_reg - 1'b1);
            end
            ST_SHWR:
            begin
                tab_we    = 1'b1;
                tab_waddr = m_reg[spm_pkg::TABLE_AW-1:0];
                tab_wdata = tab_rdata;
            end
            ST_INS:
            begin
                tab_we    = 1'b1;
                tab_waddr = pos_reg[spm_pkg::TABLE_AW-1:0];
                tab_wdata = {prod_coef_reg, prod_exp_reg};
            end
            default:
            begin
                tab_we = 1'b0;
            end
        endcase
    end

    spm_table_ram #(
        .DATA_W (DW),
        .ADDR_W (spm_pkg::TABLE_AW)
    ) u_table (
        .clk     (clk),
        .wr_en   (tab_we),
        .wr_addr (tab_waddr),
        .wr_data (tab_wdata),
        .rd_addr (tab_raddr),
        .rd_data (tab_rdata)
    );

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            first_count_reg  <= '0;
            second_count_reg <= '0;
            dropped_reg      <= 1'b0;
            ovf_reg          <= 1'b0;
            out_valid_reg    <= 1'b0;
            out_coef_reg     <= '0;
            out_exp_reg      <= '0;
            out_last_reg     <= 1'b0;
            out_empty_reg    <= 1'b0;
            out_ovf_reg      <= 1'b0;
            prod_coef_reg    <= '0;
            prod_exp_reg     <= '0;
            i_reg            <= '0;
            j_reg            <= '0;
            k_reg            <= '0;
            pos_reg          <= '0;
            m_reg            <= '0;
            pcount_reg       <= '0;
        end
        else
        begin
            if (out_valid_reg && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        case (s_axis_tuser)
                            spm_pkg::CMD_LOAD_FIRST:
                            begin
                                if (first_full) dropped_reg <= 1'b1;
                                else first_count_reg <= first_count_reg + 1'b1;
                            end
                            spm_pkg::CMD_LOAD_SECOND:
                            begin
                                if (second_full) dropped_reg <= 1'b1;
                                else second_count_reg <= second_count_reg + 1'b1;
                            end
                            spm_pkg::CMD_MULTIPLY:
                            begin
                                ovf_reg <= dropped_reg;
                                if (first_count_reg == '0 || second_count_reg == '0)
                                begin
                                    // empty product: one flagged word
                                    out_valid_reg    <= 1'b1;
                                    out_coef_reg     <= '0;
                                    out_exp_reg      <= '0;
                                    out_last_reg     <= 1'b1;
                                    out_empty_reg    <= 1'b1;
                                    out_ovf_reg      <= dropped_reg;
                                    first_count_reg  <= '0;
                                    second_count_reg <= '0;
                                    dropped_reg      <= 1'b0;
                                end
                                else
                                begin
                                    i_reg      <= '0;
                                    j_reg      <= '0;
                                    pcount_reg <= '0;
                                    state_reg  <= ST_RD;
                                end
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_RD:
                begin
                    state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    prod_coef_reg <= a_rd_reg.coef * b_rd_reg.coef;
                    prod_exp_reg  <= {a_rd_reg.exp[EXP_BITS-1], a_rd_reg.exp}
                                   + {b_rd_reg.exp[EXP_BITS-1], b_rd_reg.exp};
                    k_reg         <= '0;
                    state_reg     <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    if (k_reg == pcount_reg)
                    begin
                        pos_reg   <= k_reg;
                        state_reg <= (pcount_reg == spm_pkg::PCOUNT_W'(spm_pkg::TABLE_CAP))
                                     ? ST_NEXT : ST_INS;
                    end
                    else
                    begin
                        state_reg <= ST_CMP;
                    end
                end
                ST_CMP:
                begin
                    if (tab_exp == prod_exp_reg)
                    begin
                        state_reg <= ST_NEXT;
                    end
                    else if (tab_exp > prod_exp_reg)
                    begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= ST_SCAN;
                    end
                    else
                    begin
                        pos_reg   <= k_reg;
                        m_reg     <= pcount_reg;
                        state_reg <= ST_SHRD;
                    end
                end
                ST_SHRD:
                begin
                    state_reg <= (m_reg == pos_reg) ? ST_INS : ST_SHWR;
                end
                ST_SHWR:
                begin
                    m_reg     <= m_reg - 1'b1;
                    state_reg <= ST_SHRD;
                end
                ST_INS:
                begin
                    pcount_reg <= pcount_reg + 1'b1;
                    state_reg  <= ST_NEXT;
                end
                ST_NEXT:
                begin
                    if (j_reg == second_count_reg - 1'b1)
                    begin
                        j_reg <= '0;
                        if (i_reg == first_count_reg - 1'b1)
                        begin
                            k_reg     <= '0;
                            state_reg <= ST_EMRD;
                        end
                        else
                        begin
                            i_reg     <= i_reg + 1'b1;
                            state_reg <= ST_RD;
                        end
                    end
                    else
                    begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= ST_RD;
                    end
                end
                ST_EMRD:
                begin
                    if (!out_valid_reg)
                    begin
                        state_reg <= ST_EMLD;
                    end
                end
                ST_EMLD:
                begin
                    out_valid_reg <= 1'b1;
                    out_coef_reg  <= tab_coef;
                    out_exp_reg   <= out_exp_cvt;
                    out_last_reg  <= (k_reg == pcount_reg - 1'b1);
                    out_empty_reg <= 1'b0;
                    out_ovf_reg   <= ovf_reg;
                    k_reg         <= k_reg + 1'b1;
                    if (k_reg == pcount_reg - 1'b1)
                    begin
                        first_count_reg  <= '0;
                        second_count_reg <= '0;
                        dropped_reg      <= 1'b0;
                        state_reg        <= ST_IDLE;
                    end
                    else
                    begin
                        state_reg <= ST_EMRD;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // an empty word is always the last word and carries no term
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast && m_axis_tdata == '0)
        else $error("empty word without last or with data");

    // the table never grows past its capacity
    a_pcount_cap: assert property (@(posedge clk) disable iff (!rst_n)
        pcount_reg <= spm_pkg::PCOUNT_W'(spm_pkg::TABLE_CAP))
        else $error("product count beyond table capacity");

    // the scan pointer never passes the fill level
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN || state_reg == ST_CMP |-> k_reg <= pcount_reg)
        else $error("scan pointer beyond fill level");

    // a shift only runs while there is room for the new entry
    a_shift_room: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SHWR |-> m_reg < spm_pkg::PCOUNT_W'(spm_pkg::TABLE_CAP))
        else $error("shift writes beyond table");

endmodule

/* hw/rtl/spm_table_ram.sv */
module spm_table_ram #(
    parameter int DATA_W = 49,
    parameter int ADDR_W = 6
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
